### rtl/oss_pkg.sv
// shared types, constants and bit-search helpers for the ordered set successor block
// used by oss_ctrl, oss_dpath and ordered_set_successor; depends on nothing else
package oss_pkg;

	localparam int VALUE_BITS = 17;
	localparam int WORD_BITS  = 64;
	localparam int BIT_W      = $clog2(WORD_BITS);
	localparam int WORD_W     = VALUE_BITS - BIT_W;
	localparam int SUM_W      = WORD_W - BIT_W;
	localparam int NUM_WORDS  = 1 << WORD_W;
	localparam int NUM_SUM    = 1 << SUM_W;

	typedef enum logic [1:0] {
		OP_MIN_GE = 2'd0,
		OP_MIN_GT = 2'd1,
		OP_INSERT = 2'd2,
		OP_REMOVE = 2'd3
	} op_t;

	typedef struct packed {
		op_t                   op;
		logic [VALUE_BITS-1:0] value;
	} req_t;

	typedef struct packed {
		logic                  found;
		logic [VALUE_BITS-1:0] member;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_WORD = 2'd1,
		ST_SUM  = 2'd2,
		ST_LAST = 2'd3
	} state_t;

	typedef enum logic [1:0] {
		RD_REQ  = 2'd0,
		RD_NEAR = 2'd1,
		RD_FAR  = 2'd2
	} rd_sel_t;

	typedef enum logic [1:0] {
		RES_NONE = 2'd0,
		RES_WORD = 2'd1,
		RES_LAST = 2'd2
	} res_sel_t;

	typedef struct packed {
		logic     capture;
		logic     update;
		logic     mem_rd;
		rd_sel_t  rd_sel;
		logic     far_take;
		logic     emit;
		res_sel_t res_sel;
	} cmd_t;

	typedef struct packed {
		logic is_update;
		logic over;
		logic word_hit;
		logic near_hit;
		logic far_hit;
	} stat_t;

	// index of the lowest set bit, zero when none
	function automatic logic [BIT_W-1:0] lowest_word(input logic [WORD_BITS-1:0] x);
		logic [BIT_W-1:0] idx;
		idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (x[i]) idx = BIT_W'(i);
		end
		return idx;
	endfunction

	function automatic logic [SUM_W-1:0] lowest_sum(input logic [NUM_SUM-1:0] x);
		logic [SUM_W-1:0] idx;
		idx = '0;
		for (int i = NUM_SUM - 1; i >= 0; i--) begin
			if (x[i]) idx = SUM_W'(i);
		end
		return idx;
	endfunction

endpackage

### rtl/oss_ctrl.sv
// sequencing state machine for the ordered set successor block
// depends on oss_pkg; drives oss_dpath through cmd_t and reads stat_t
module oss_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  oss_pkg::stat_t stat,
	output logic           busy,
	output oss_pkg::cmd_t  cmd
);
	import oss_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_WORD;
			end
			ST_WORD: begin
				if (stat.is_update || stat.over || stat.word_hit) begin
					state_d = ST_IDLE;
				end else if (stat.near_hit) begin
					state_d = ST_LAST;
				end else if (stat.far_hit) begin
					state_d = ST_SUM;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_SUM:  state_d = ST_LAST;
			ST_LAST: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					cmd.mem_rd  = 1'b1;
					cmd.rd_sel  = RD_REQ;
				end
			end
			ST_WORD: begin
				if (stat.is_update) begin
					cmd.update = 1'b1;
				end else if (stat.over) begin
					cmd.emit    = 1'b1;
					cmd.res_sel = RES_NONE;
				end else if (stat.word_hit) begin
					cmd.emit    = 1'b1;
					cmd.res_sel = RES_WORD;
				end else if (stat.near_hit) begin
					cmd.mem_rd = 1'b1;
					cmd.rd_sel = RD_NEAR;
				end else if (stat.far_hit) begin
					cmd.far_take = 1'b1;
				end else begin
					cmd.emit    = 1'b1;
					cmd.res_sel = RES_NONE;
				end
			end
			ST_SUM: begin
				cmd.mem_rd = 1'b1;
				cmd.rd_sel = RD_FAR;
			end
			ST_LAST: begin
				cmd.emit    = 1'b1;
				cmd.res_sel = RES_LAST;
			end
			default: cmd = '0;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

### rtl/oss_dpath.sv
// datapath: presence word memory, summary words, top-level nonempty mask, result register
// depends on oss_pkg; controlled by oss_ctrl
module oss_dpath (
	input  logic           clk,
	input  logic           arst_n,
	input  oss_pkg::req_t  request,
	input  oss_pkg::cmd_t  cmd,
	output oss_pkg::stat_t stat,
	output logic           done,
	output oss_pkg::rsp_t  result
);
	import oss_pkg::*;

	logic [WORD_BITS-1:0]  mem [NUM_WORDS];
	logic [WORD_BITS-1:0]  rdata_q;
	logic [WORD_BITS-1:0]  summary_q [NUM_SUM];
	logic [NUM_SUM-1:0]    top_q;
	logic [WORD_BITS-1:0]  sw_q;
	logic [SUM_W-1:0]      s2_q;
	logic [WORD_W-1:0]     nw_q;
	op_t                   op_q;
	logic [VALUE_BITS-1:0] key_q;
	logic                  over_q;
	rsp_t                  res_q;
	logic                  done_q;

	logic [VALUE_BITS:0]   cap_key;
	logic [SUM_W-1:0]      cap_s;
	logic [WORD_W-1:0]     kw;
	logic [BIT_W-1:0]      kb;
	logic [SUM_W-1:0]      ks;
	logic [BIT_W-1:0]      ksb;
	logic [WORD_BITS-1:0]  word;
	logic [WORD_BITS-1:0]  hit_bits;
	logic [WORD_BITS-1:0]  above_mask;
	logic [WORD_BITS-1:0]  sum_above;
	logic [NUM_SUM-1:0]    top_mask;
	logic [NUM_SUM-1:0]    top_above;
	logic [BIT_W-1:0]      near_idx;
	logic [SUM_W-1:0]      far_s;
	logic [SUM_W-1:0]      sum_raddr;
	logic [WORD_W-1:0]     rd_addr;
	logic [WORD_BITS-1:0]  bit_mask;
	logic [WORD_BITS-1:0]  new_word;
	logic [WORD_BITS-1:0]  sw_new;
	rsp_t                  res_d;

	// an upper bound query moves the key up by one; it may run past the domain
	assign cap_key = {1'b0, request.value}
		+ ((request.op == OP_MIN_GT) ? (VALUE_BITS+1)'(1) : (VALUE_BITS+1)'(0));
	assign cap_s   = cap_key[VALUE_BITS-1:VALUE_BITS-SUM_W];

	assign kw  = key_q[VALUE_BITS-1:BIT_W];
	assign kb  = key_q[BIT_W-1:0];
	assign ks  = kw[WORD_W-1:BIT_W];
	assign ksb = kw[BIT_W-1:0];

	// a presence word only holds real data while its summary bit is set
	assign word       = sw_q[ksb] ? rdata_q : '0;
	assign hit_bits   = word & ({WORD_BITS{1'b1}} << kb);
	assign above_mask = ({WORD_BITS{1'b1}} << ksb) << 1;
	assign sum_above  = sw_q & above_mask;
	assign top_mask   = ({NUM_SUM{1'b1}} << ks) << 1;
	assign top_above  = top_q & top_mask;
	assign near_idx   = lowest_word(sum_above);
	assign far_s      = lowest_sum(top_above);
	assign sum_raddr  = cmd.capture ? cap_s : far_s;

	assign bit_mask = WORD_BITS'(1) << kb;
	assign new_word = (op_q == OP_INSERT) ? (word | bit_mask) : (word & ~bit_mask);
	assign sw_new   = (|new_word) ? (sw_q | (WORD_BITS'(1) << ksb))
	                              : (sw_q & ~(WORD_BITS'(1) << ksb));

	always_comb begin
		case (cmd.rd_sel)
			RD_REQ:  rd_addr = cap_key[VALUE_BITS-1:BIT_W];
			RD_NEAR: rd_addr = {ks, near_idx};
			RD_FAR:  rd_addr = {s2_q, lowest_word(sw_q)};
			default: rd_addr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.update) mem[kw] <= new_word;
		if (cmd.mem_rd) rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SUM; i++) summary_q[i] <= '0;
			top_q <= '0;
		end else if (cmd.update) begin
			summary_q[ks] <= sw_new;
			top_q[ks]     <= |sw_new;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= request.op;
			key_q  <= cap_key[VALUE_BITS-1:0];
			over_q <= cap_key[VALUE_BITS];
		end
		if (cmd.capture || cmd.far_take) sw_q <= summary_q[sum_raddr];
		if (cmd.far_take) s2_q <= far_s;
		if (cmd.mem_rd) nw_q <= rd_addr;
		if (cmd.emit) res_q <= res_d;
	end

	always_comb begin
		res_d = '0;
		case (cmd.res_sel)
			RES_WORD: begin
				res_d.found  = 1'b1;
				res_d.member = {kw, lowest_word(hit_bits)};
			end
			RES_LAST: begin
				res_d.found  = |rdata_q;
				res_d.member = (|rdata_q) ? {nw_q, lowest_word(rdata_q)} : '0;
			end
			default: res_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit;
		end
	end

	assign stat.is_update = (op_q == OP_INSERT) || (op_q == OP_REMOVE);
	assign stat.over      = over_q;
	assign stat.word_hit  = |hit_bits;
	assign stat.near_hit  = |sum_above;
	assign stat.far_hit   = |top_above;

	assign done   = done_q;
	assign result = res_q;

endmodule

### rtl/ordered_set_successor.sv
// Ordered integer set with lower bound / upper bound queries.
// Requests: drive request (op, value) with start; it is taken at a clock edge where start
// is high and busy is low. insert and remove change the set and give no result.
// lower bound and upper bound queries each give one result: done is high for exactly
// one cycle with result (found, member); member is zero when nothing qualifies.
// The receiver cannot stall; a result must be taken in the cycle it is shown.
// Steps, counted from the accepting edge; the key's own word is read first:
//   insert / remove .................. the word, its summary word and top mask bit are written, no result
//   query hit in the key's own word .. result from that word
//   hit found in the same summary word a second read, of the next nonempty word
//   hit through the top-level mask ... summary word fetched via the mask, then a second read
// The single-port presence word memory sets these steps: one read for the key's word
// and one more read for the next nonempty word. A new request may start in the cycle
// that done is high.
// Reset (arst_n low) empties the set at once: summary words and top mask are flops
// that clear, and a presence word is only trusted while its summary bit is set, so no
// clearing pass runs. Depends on oss_pkg, oss_ctrl and oss_dpath.
module ordered_set_successor (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  oss_pkg::req_t request,
	output logic          busy,
	output logic          done,
	output oss_pkg::rsp_t result
);
	import oss_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	oss_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	oss_dpath u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.cmd     (cmd),
		.stat    (stat),
		.done    (done),
		.result  (result)
	);

endmodule

### bench/tb_top.sv
// self-checking bench for ordered_set_successor: insert, remove and successor queries
// carries its own bitmap predictor in a small scoreboard class; depends on oss_pkg and ordered_set_successor
`timescale 1ns / 1ps

module tb_top;
	import oss_pkg::*;

	localparam int unsigned TOP_VALUE   = (1 << VALUE_BITS) - 1;
	localparam int          QUIET_LIMIT = 1000;
	localparam int          RANDOM_REQS = 830;

	class successor_scoreboard;
		bit [WORD_BITS-1:0] words [NUM_WORDS];
		bit [WORD_BITS-1:0] summary [NUM_SUM];
		rsp_t               expected_q[$];
		int                 errors;

		function new();
			errors = 0;
		endfunction

		// smallest member at or above key, key inside the domain
		function rsp_t successor_of(int unsigned key);
			int unsigned w, nw;
			rsp_t hit;
			hit = '0;
			w = key / WORD_BITS;
			for (int i = key % WORD_BITS; i < WORD_BITS; i++) begin
				if (words[w][i]) begin
					hit.found  = 1'b1;
					hit.member = VALUE_BITS'(w * WORD_BITS + i);
					return hit;
				end
			end
			nw = w + 1;
			while (nw < NUM_WORDS) begin
				if (summary[nw / WORD_BITS] == '0) begin
					nw = (nw / WORD_BITS + 1) * WORD_BITS;
				end else if (summary[nw / WORD_BITS][nw % WORD_BITS]) begin
					for (int i = 0; i < WORD_BITS; i++) begin
						if (words[nw][i]) begin
							hit.found  = 1'b1;
							hit.member = VALUE_BITS'(nw * WORD_BITS + i);
							return hit;
						end
					end
					return hit;
				end else begin
					nw++;
				end
			end
			return hit;
		endfunction

		function void note_request(req_t req);
			int unsigned v, w, b;
			v = req.value;
			w = v / WORD_BITS;
			b = v % WORD_BITS;
			case (req.op)
				OP_INSERT: begin
					words[w][b] = 1'b1;
					summary[w / WORD_BITS][w % WORD_BITS] = 1'b1;
				end
				OP_REMOVE: begin
					words[w][b] = 1'b0;
					if (words[w] == '0) summary[w / WORD_BITS][w % WORD_BITS] = 1'b0;
				end
				OP_MIN_GE: expected_q.push_back(successor_of(v));
				OP_MIN_GT: begin
					// nothing lies above the top of the domain
					if (v == TOP_VALUE) expected_q.push_back(rsp_t'(0));
					else expected_q.push_back(successor_of(v + 1));
				end
				default: ;
			endcase
		endfunction

		task report(string what);
			$display("%0t mismatch: %s", $time, what);
			errors++;
		endtask

		task check_result(rsp_t got);
			rsp_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("result found=%0b member=%0d with no query waiting",
					got.found, got.member));
			end else begin
				want = expected_q.pop_front();
				if (got.found !== want.found)
					report($sformatf("found %0b, want %0b", got.found, want.found));
				if (got.member !== want.member)
					report($sformatf("member %0d, want %0d", got.member, want.member));
			end
		endtask

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  start = 1'b0;
	req_t  request = '0;
	logic  busy;
	logic  done;
	rsp_t  result;

	successor_scoreboard sb;
	int unsigned         members_q[$];
	bit                  burst = 1'b0;
	int                  quiet_cycles = 0;

	ordered_set_successor dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.request (request),
		.busy    (busy),
		.done    (done),
		.result  (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (burst || r < 55) return 0;
		if (r < 85) return $urandom_range(1, 4);
		if (r < 97) return $urandom_range(5, 12);
		return $urandom_range(20, 60);
	endfunction

	// clustered values so queries land in the own word, the same summary word or far away
	function int unsigned pick_value();
		int r;
		int unsigned hot [4];
		hot = '{0, 4032, 65500, 130800};
		r = $urandom_range(0, 99);
		if (r < 3) return ($urandom_range(0, 1) != 0) ? TOP_VALUE : 0;
		if (r < 28) return $urandom_range(0, TOP_VALUE);
		if (r < 58 && members_q.size() > 0)
			return (members_q[$urandom_range(0, members_q.size() - 1)]
				+ $urandom_range(0, 140) - 70) & TOP_VALUE;
		return (hot[$urandom_range(0, 3)] + $urandom_range(0, 511)) & TOP_VALUE;
	endfunction

	task send(op_t op, int unsigned v);
		int gap;
		start   <= 1'b1;
		request <= '{op, VALUE_BITS'(v)};
		if (op == OP_INSERT) members_q.push_back(v);
		do @(posedge clk); while (busy);
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) sb.check_result(result);
			if (start && !busy) sb.note_request(request);
			if (done || (start && !busy)) begin
				quiet_cycles = 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end else begin
				quiet_cycles++;
			end
		end
	end

	initial begin
		int r, idx;
		int unsigned v;
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty set, domain edges, duplicates, absent removes, word and summary crossings
		send(OP_MIN_GE, 0);
		send(OP_MIN_GT, TOP_VALUE);
		send(OP_INSERT, 0);
		send(OP_INSERT, TOP_VALUE);
		send(OP_INSERT, 0);
		send(OP_MIN_GE, 0);
		send(OP_MIN_GT, 0);
		send(OP_MIN_GE, 1);
		send(OP_INSERT, 64);
		send(OP_MIN_GT, 0);
		send(OP_INSERT, 4096);
		send(OP_MIN_GT, 64);
		send(OP_MIN_GE, 65);
		send(OP_MIN_GT, TOP_VALUE);
		send(OP_MIN_GE, TOP_VALUE);
		send(OP_REMOVE, 5);
		send(OP_REMOVE, TOP_VALUE);
		send(OP_MIN_GE, 4097);
		send(OP_REMOVE, 4096);
		send(OP_MIN_GE, 65);
		send(OP_REMOVE, 64);
		send(OP_REMOVE, 0);
		send(OP_MIN_GE, 0);
		members_q.delete();

		for (int i = 0; i < RANDOM_REQS; i++) begin
			if (i % 100 == 0) burst = ($urandom_range(0, 3) == 0);
			if (i % 200 == 199) begin
				// hold off until every query has answered
				start <= 1'b0;
				@(posedge clk);
				while (sb.pending() != 0) @(posedge clk);
			end
			if (i == RANDOM_REQS / 2) begin
				// empty the set, then ask into the void
				while (members_q.size() > 0) send(OP_REMOVE, members_q.pop_back());
				send(OP_MIN_GE, 0);
				send(OP_MIN_GT, $urandom_range(0, TOP_VALUE));
			end
			r = $urandom_range(0, 99);
			if (r < 38) begin
				send(OP_INSERT, pick_value());
			end else if (r < 55) begin
				if (members_q.size() > 0 && $urandom_range(0, 9) < 7) begin
					idx = $urandom_range(0, members_q.size() - 1);
					v = members_q[idx];
					members_q.delete(idx);
					send(OP_REMOVE, v);
				end else begin
					send(OP_REMOVE, pick_value());
				end
			end else if (r < 78) begin
				send(OP_MIN_GE, pick_value());
			end else begin
				send(OP_MIN_GT, pick_value());
			end
		end

		start <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
